// File: rtl/tlrg_pkg.sv
`timescale 1ns / 1ps
package tlrg_pkg;

  localparam int AP_N   = 4;
  localparam int PX_N   = 2;
  localparam int AP_W   = (AP_N > 1) ? $clog2(AP_N) : 1;
  localparam int PX_W   = (PX_N > 1) ? $clog2(PX_N) : 1;
  localparam int AP_DEN = 2 * AP_N;
  localparam int PX_DEN = 2 * PX_N;

  // Pipelined restoring divider: 64-bit dividend, 32-bit divisor, 49 quotient bits.
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;
  localparam int DIV_QW = 49;

  // Pipelined square root: 64-bit radicand, 32 root bits.
  localparam int SQ_RW = 64;
  localparam int SQ_W  = 32;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] UZ_BASE = 32'h0001_0000;

  typedef enum logic [2:0] {
    REG_DIAM  = 3'd0,
    REG_DISK  = 3'd1,
    REG_ZDIST = 3'd2,
    REG_IFL   = 3'd3,
    REG_ORGX  = 3'd4,
    REG_ORGY  = 3'd5,
    REG_PITX  = 3'd6,
    REG_PITY  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic [30:0]        dir_z;
    logic               last_ray;
  } out_item_t;

  typedef struct packed {
    logic            vld;
    logic            last;
    logic [11:0]     px;
    logic [11:0]     py;
    logic [AP_W-1:0] ai;
    logic [AP_W-1:0] aj;
    logic [PX_W-1:0] pk;
    logic [PX_W-1:0] pl;
  } smp_t;

  function automatic logic signed [4:0] ap_coord(input logic [AP_W-1:0] i);
    return 5'(2 * int'(i) + 1 - AP_N);
  endfunction

  function automatic logic ap_pass(input logic [AP_W-1:0] i, input logic [AP_W-1:0] j,
                                   input logic disk);
    int ci;
    int cj;
    ci = 2 * int'(i) + 1 - AP_N;
    cj = 2 * int'(j) + 1 - AP_N;
    return !disk || (ci * ci + cj * cj < AP_N * AP_N);
  endfunction

  // True when no aperture sample after (i, j) in visit order survives the disk test.
  function automatic logic ap_last(input logic [AP_W-1:0] i, input logic [AP_W-1:0] j,
                                   input logic disk);
    int   self_idx;
    logic res;
    self_idx = int'(i) * AP_N + int'(j);
    res = 1'b1;
    for (int ii = 0; ii < AP_N; ii++) begin
      for (int jj = 0; jj < AP_N; jj++) begin
        if ((ii * AP_N + jj > self_idx) && ap_pass(AP_W'(ii), AP_W'(jj), disk)) begin
          res = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -51'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: rtl/tlrg_div.sv
`timescale 1ns / 1ps
module tlrg_div import tlrg_pkg::*; (
  input  logic              clk,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_QW-1:0] quo
);

  // One quotient bit per stage. The dividend bits above the quotient field
  // preload the remainder, so they must be smaller than the divisor.
  logic [DIV_DW-1:0] rem_r   [DIV_QW];
  logic [DIV_QW-1:0] low_r   [DIV_QW];
  logic [DIV_DW-1:0] den_r   [DIV_QW];
  logic [DIV_QW-1:0] quo_r   [DIV_QW];
  logic [DIV_DW-1:0] rem_nxt [DIV_QW];
  logic [DIV_QW-1:0] low_nxt [DIV_QW];
  logic [DIV_DW-1:0] den_nxt [DIV_QW];
  logic [DIV_QW-1:0] quo_nxt [DIV_QW];
  logic [DIV_DW-1:0] rem_in  [DIV_QW];
  logic [DIV_QW-1:0] low_in  [DIV_QW];
  logic [DIV_QW-1:0] quo_in  [DIV_QW];
  logic [DIV_DW:0]   trial   [DIV_QW];
  logic              ge      [DIV_QW];

  always_comb begin
    for (int s = 0; s < DIV_QW; s++) begin
      if (s == 0) begin
        rem_in[s]  = DIV_DW'(num[DIV_NW-1:DIV_QW]);
        low_in[s]  = num[DIV_QW-1:0];
        quo_in[s]  = '0;
        den_nxt[s] = den;
      end else begin
        rem_in[s]  = rem_r[s-1];
        low_in[s]  = low_r[s-1];
        quo_in[s]  = quo_r[s-1];
        den_nxt[s] = den_r[s-1];
      end
      trial[s]   = {rem_in[s], low_in[s][DIV_QW-1]};
      ge[s]      = trial[s] >= {1'b0, den_nxt[s]};
      rem_nxt[s] = ge[s] ? DIV_DW'(trial[s] - {1'b0, den_nxt[s]}) : trial[s][DIV_DW-1:0];
      low_nxt[s] = low_in[s] << 1;
      quo_nxt[s] = {quo_in[s][DIV_QW-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_QW; s++) begin
      rem_r[s] <= rem_nxt[s];
      low_r[s] <= low_nxt[s];
      den_r[s] <= den_nxt[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign quo = quo_r[DIV_QW-1];

endmodule

// File: rtl/tlrg_sqrt.sv
`timescale 1ns / 1ps
module tlrg_sqrt import tlrg_pkg::*; (
  input  logic             clk,
  input  logic [SQ_RW-1:0] rad,
  output logic [SQ_W-1:0]  root
);

  // Digit-by-digit integer square root, one root bit per stage.
  logic [SQ_RW-1:0] rad_r    [SQ_W];
  logic [SQ_W+1:0]  rem_r    [SQ_W];
  logic [SQ_W-1:0]  root_r   [SQ_W];
  logic [SQ_RW-1:0] rad_nxt  [SQ_W];
  logic [SQ_W+1:0]  rem_nxt  [SQ_W];
  logic [SQ_W-1:0]  root_nxt [SQ_W];
  logic [SQ_RW-1:0] rad_in   [SQ_W];
  logic [SQ_W+1:0]  rem_in   [SQ_W];
  logic [SQ_W-1:0]  root_in  [SQ_W];
  logic [SQ_W+3:0]  cur      [SQ_W];
  logic [SQ_W+3:0]  trial    [SQ_W];
  logic             ge       [SQ_W];

  always_comb begin
    for (int s = 0; s < SQ_W; s++) begin
      if (s == 0) begin
        rad_in[s]  = rad;
        rem_in[s]  = '0;
        root_in[s] = '0;
      end else begin
        rad_in[s]  = rad_r[s-1];
        rem_in[s]  = rem_r[s-1];
        root_in[s] = root_r[s-1];
      end
      cur[s]      = {rem_in[s], rad_in[s][SQ_RW-1:SQ_RW-2]};
      trial[s]    = (SQ_W+4)'({root_in[s], 2'b01});
      ge[s]       = cur[s] >= trial[s];
      rem_nxt[s]  = ge[s] ? (SQ_W+2)'(cur[s] - trial[s]) : cur[s][SQ_W+1:0];
      root_nxt[s] = {root_in[s][SQ_W-2:0], ge[s]};
      rad_nxt[s]  = rad_in[s] << 2;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SQ_W; s++) begin
      rad_r[s]  <= rad_nxt[s];
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
    end
  end

  assign root = root_r[SQ_W-1];

endmodule

// File: rtl/tlrg_seq.sv
`timescale 1ns / 1ps
module tlrg_seq import tlrg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_data,
  input  logic     disk,
  output smp_t     smp
);

  logic            act_r, act_nxt;
  logic [11:0]     px_r, px_nxt;
  logic [11:0]     py_r, py_nxt;
  logic [AP_W-1:0] ai_r, ai_nxt;
  logic [AP_W-1:0] aj_r, aj_nxt;
  logic [PX_W-1:0] pk_r, pk_nxt;
  logic [PX_W-1:0] pl_r, pl_nxt;
  logic            i_end, j_end, k_end, l_end, fin, accept;

  assign i_end  = ai_r == AP_W'(AP_N - 1);
  assign j_end  = aj_r == AP_W'(AP_N - 1);
  assign k_end  = pk_r == PX_W'(PX_N - 1);
  assign l_end  = pl_r == PX_W'(PX_N - 1);
  assign fin    = i_end && j_end && k_end && l_end;
  // The next pixel is taken in the same cycle as the final sample slot.
  assign busy   = act_r && !fin;
  assign accept = start && !busy;

  always_comb begin
    act_nxt = act_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    ai_nxt  = ai_r;
    aj_nxt  = aj_r;
    pk_nxt  = pk_r;
    pl_nxt  = pl_r;
    if (accept) begin
      act_nxt = 1'b1;
      px_nxt  = in_data.pixel_x;
      py_nxt  = in_data.pixel_y;
      ai_nxt  = '0;
      aj_nxt  = '0;
      pk_nxt  = '0;
      pl_nxt  = '0;
    end else if (act_r) begin
      if (fin) begin
        act_nxt = 1'b0;
      end
      pl_nxt = l_end ? '0 : pl_r + 1'b1;
      if (l_end) begin
        pk_nxt = k_end ? '0 : pk_r + 1'b1;
        if (k_end) begin
          aj_nxt = j_end ? '0 : aj_r + 1'b1;
          if (j_end) begin
            ai_nxt = i_end ? '0 : ai_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ai_r  <= '0;
      aj_r  <= '0;
      pk_r  <= '0;
      pl_r  <= '0;
    end else begin
      act_r <= act_nxt;
      ai_r  <= ai_nxt;
      aj_r  <= aj_nxt;
      pk_r  <= pk_nxt;
      pl_r  <= pl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
  end

  always_comb begin
    smp.vld  = act_r && ap_pass(ai_r, aj_r, disk);
    smp.last = smp.vld && k_end && l_end && ap_last(ai_r, aj_r, disk);
    smp.px   = px_r;
    smp.py   = py_r;
    smp.ai   = ai_r;
    smp.aj   = aj_r;
    smp.pk   = pk_r;
    smp.pl   = pl_r;
  end

endmodule

// File: rtl/thin_lens_ray_generator_top.sv
`timescale 1ns / 1ps
// Throughput: one sample slot per cycle from the sample sequencer, 64 slots per pixel; a new
// start is taken in the last slot of the prior pixel; disk-rejected samples leave empty slots.
// The result strobe cannot be stalled, so the pipeline never holds.
// Reset (rst_n low, synchronous) restores register defaults and empties the pipeline.
module thin_lens_ray_generator_top import tlrg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef struct packed {
    logic               last;
    logic               negx;
    logic               negy;
    logic signed [48:0] termx;
    logic signed [48:0] termy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
  } side1_t;

  typedef struct packed {
    logic               last;
    logic               negx;
    logic               negy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [31:0]        ux;
    logic [31:0]        uy;
    logic [31:0]        uz;
  } side2_t;

  typedef struct packed {
    logic               last;
    logic               negx;
    logic               negy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
  } side3_t;

  // Configuration registers.
  logic [30:0]        diam_r;
  logic               disk_r;
  logic signed [31:0] zdist_r, ifl_r, orgx_r, orgy_r, pitx_r, pity_r;
  logic               wr_en;
  reg_idx_t           widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r  <= 31'd65536;
      disk_r  <= 1'b0;
      zdist_r <= -32'sd65536;
      ifl_r   <= '0;
      orgx_r  <= -32'sd65536;
      orgy_r  <= -32'sd65536;
      pitx_r  <= 32'sd32;
      pity_r  <= 32'sd32;
    end else if (wr_en) begin
      case (widx)
        REG_DIAM:  diam_r  <= pwdata[30:0];
        REG_DISK:  disk_r  <= pwdata[0];
        REG_ZDIST: zdist_r <= pwdata;
        REG_IFL:   ifl_r   <= pwdata;
        REG_ORGX:  orgx_r  <= pwdata;
        REG_ORGY:  orgy_r  <= pwdata;
        REG_PITX:  pitx_r  <= pwdata;
        REG_PITY:  pity_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_DIAM:  prdata = {1'b0, diam_r};
      REG_DISK:  prdata = {31'b0, disk_r};
      REG_ZDIST: prdata = zdist_r;
      REG_IFL:   prdata = ifl_r;
      REG_ORGX:  prdata = orgx_r;
      REG_ORGY:  prdata = orgy_r;
      REG_PITX:  prdata = pitx_r;
      REG_PITY:  prdata = pity_r;
      default:   prdata = '0;
    endcase
  end

  // Sample sequencer.
  smp_t smp;

  tlrg_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .disk    (disk_r),
    .smp     (smp)
  );

  // Stage 1: aperture point and image-plane products.
  logic signed [4:0]  cx, cy;
  logic [2:0]         cxm, cym;
  logic [33:0]        axp, ayp, axq, ayq;
  logic [16:0]        pmx, pmy;
  logic               s1_vld_r, s1_last_r;
  logic signed [31:0] s1_ax_r, s1_ay_r;
  logic signed [48:0] s1_imx_r, s1_imy_r;

  always_comb begin
    cx  = ap_coord(smp.ai);
    cy  = ap_coord(smp.aj);
    cxm = cx[4] ? 3'(-cx) : 3'(cx);
    cym = cy[4] ? 3'(-cy) : 3'(cy);
    axp = 34'(diam_r) * 34'(cxm);
    ayp = 34'(diam_r) * 34'(cym);
    axq = (axp + 34'(AP_N)) / 34'(AP_DEN);
    ayq = (ayp + 34'(AP_N)) / 34'(AP_DEN);
    pmx = 17'(smp.px) * 17'(PX_DEN) + 17'(smp.pk) * 17'd2 + 17'd1;
    pmy = 17'(smp.py) * 17'(PX_DEN) + 17'(smp.pl) * 17'd2 + 17'd1;
  end

  always_ff @(posedge clk) begin
    s1_ax_r  <= cx[4] ? -32'(axq) : 32'(axq);
    s1_ay_r  <= cy[4] ? -32'(ayq) : 32'(ayq);
    s1_imx_r <= 49'(pitx_r) * 49'(signed'({1'b0, pmx}));
    s1_imy_r <= 49'(pity_r) * 49'(signed'({1'b0, pmy}));
    s1_last_r <= smp.last;
  end

  // Stage 2: image point with saturation, lens products.
  logic [48:0]        imxm, imym, imxq, imyq;
  logic signed [49:0] imxv, imyv;
  logic               s2_vld_r, s2_last_r;
  logic signed [31:0] s2_ax_r, s2_ay_r, s2_gx_r, s2_gy_r;
  logic signed [63:0] s2_fpx_r, s2_fpy_r;

  always_comb begin
    imxm = s1_imx_r[48] ? 49'(-s1_imx_r) : 49'(s1_imx_r);
    imym = s1_imy_r[48] ? 49'(-s1_imy_r) : 49'(s1_imy_r);
    imxq = (imxm + 49'(PX_N)) / 49'(PX_DEN);
    imyq = (imym + 49'(PX_N)) / 49'(PX_DEN);
    imxv = s1_imx_r[48] ? -50'(imxq) : 50'(imxq);
    imyv = s1_imy_r[48] ? -50'(imyq) : 50'(imyq);
  end

  always_ff @(posedge clk) begin
    s2_gx_r   <= sat32(51'(orgx_r) + 51'(imxv));
    s2_gy_r   <= sat32(51'(orgy_r) + 51'(imyv));
    s2_fpx_r  <= 64'(ifl_r) * 64'(s1_ax_r);
    s2_fpy_r  <= 64'(ifl_r) * 64'(s1_ay_r);
    s2_ax_r   <= s1_ax_r;
    s2_ay_r   <= s1_ay_r;
    s2_last_r <= s1_last_r;
  end

  // Stage 3: slope dividends and the rounded lens term.
  logic [31:0]        zabs, zden;
  logic signed [32:0] dfx, dfy;
  logic [32:0]        dmx, dmy;
  logic [63:0]        tmx, tmy, tqx, tqy;
  logic               s3_vld_r;
  logic [63:0]        s3_numx_r, s3_numy_r;
  side1_t             s3_side_r;

  always_comb begin
    zabs = zdist_r[31] ? 32'(-zdist_r) : 32'(zdist_r);
    zden = (zabs == 32'd0) ? 32'd1 : zabs;
    dfx  = 33'(s2_ax_r) - 33'(s2_gx_r);
    dfy  = 33'(s2_ay_r) - 33'(s2_gy_r);
    dmx  = dfx[32] ? 33'(-dfx) : 33'(dfx);
    dmy  = dfy[32] ? 33'(-dfy) : 33'(dfy);
    tmx  = s2_fpx_r[63] ? 64'(-s2_fpx_r) : 64'(s2_fpx_r);
    tmy  = s2_fpy_r[63] ? 64'(-s2_fpy_r) : 64'(s2_fpy_r);
    tqx  = (tmx + 64'd32768) >> 16;
    tqy  = (tmy + 64'd32768) >> 16;
  end

  always_ff @(posedge clk) begin
    s3_numx_r       <= 64'({dmx, 16'b0}) + 64'(zden >> 1);
    s3_numy_r       <= 64'({dmy, 16'b0}) + 64'(zden >> 1);
    s3_side_r.last  <= s2_last_r;
    s3_side_r.negx  <= dfx[32];
    s3_side_r.negy  <= dfy[32];
    s3_side_r.termx <= s2_fpx_r[63] ? -49'(tqx[47:0]) : 49'(tqx[47:0]);
    s3_side_r.termy <= s2_fpy_r[63] ? -49'(tqy[47:0]) : 49'(tqy[47:0]);
    s3_side_r.ax    <= s2_ax_r;
    s3_side_r.ay    <= s2_ay_r;
  end

  // Slope dividers with matching sideband delay.
  logic [DIV_QW-1:0] qsx, qsy;
  side1_t            d1_r  [DIV_QW];
  logic              d1v_r [DIV_QW];

  tlrg_div u_div_sx (.clk(clk), .num(s3_numx_r), .den(zden), .quo(qsx));
  tlrg_div u_div_sy (.clk(clk), .num(s3_numy_r), .den(zden), .quo(qsy));

  always_ff @(posedge clk) begin
    d1_r[0] <= s3_side_r;
    for (int s = 1; s < DIV_QW; s++) begin
      d1_r[s] <= d1_r[s-1];
    end
  end

  // Stage 4: slopes.
  side1_t             e1;
  logic signed [50:0] prex, prey;
  logic               s4_vld_r, s4_last_r;
  logic signed [31:0] s4_sx_r, s4_sy_r, s4_ax_r, s4_ay_r;

  always_comb begin
    e1   = d1_r[DIV_QW-1];
    prex = e1.negx ? -51'(qsx) : 51'(qsx);
    prey = e1.negy ? -51'(qsy) : 51'(qsy);
  end

  always_ff @(posedge clk) begin
    s4_sx_r   <= sat32(prex - 51'(e1.termx));
    s4_sy_r   <= sat32(prey - 51'(e1.termy));
    s4_ax_r   <= e1.ax;
    s4_ay_r   <= e1.ay;
    s4_last_r <= e1.last;
  end

  // Stage 5: magnitudes and normalizing shift.
  logic [31:0] uxa, uya, mxy, mall;
  logic [4:0]  msb;
  logic [3:0]  shc;
  logic        s5_vld_r;
  side2_t      s5_r;
  logic [3:0]  s5_sh_r;

  always_comb begin
    uxa  = s4_sx_r[31] ? 32'(-s4_sx_r) : 32'(s4_sx_r);
    uya  = s4_sy_r[31] ? 32'(-s4_sy_r) : 32'(s4_sy_r);
    mxy  = (uxa > uya) ? uxa : uya;
    mall = (mxy > UZ_BASE) ? mxy : UZ_BASE;
    msb  = '0;
    for (int b = 0; b < 32; b++) begin
      if (mall[b]) begin
        msb = 5'(b);
      end
    end
    shc = (msb >= 5'd30) ? 4'd0 : 4'(5'd30 - msb);
  end

  always_ff @(posedge clk) begin
    s5_r.last <= s4_last_r;
    s5_r.negx <= s4_sx_r[31];
    s5_r.negy <= s4_sy_r[31];
    s5_r.ax   <= s4_ax_r;
    s5_r.ay   <= s4_ay_r;
    s5_r.ux   <= uxa;
    s5_r.uy   <= uya;
    s5_r.uz   <= UZ_BASE;
    s5_sh_r   <= shc;
  end

  // Stage 6: shift.
  logic   s6_vld_r;
  side2_t s6_r;

  always_ff @(posedge clk) begin
    s6_r.last <= s5_r.last;
    s6_r.negx <= s5_r.negx;
    s6_r.negy <= s5_r.negy;
    s6_r.ax   <= s5_r.ax;
    s6_r.ay   <= s5_r.ay;
    s6_r.ux   <= s5_r.ux << s5_sh_r;
    s6_r.uy   <= s5_r.uy << s5_sh_r;
    s6_r.uz   <= s5_r.uz << s5_sh_r;
  end

  // Stage 7: squares. Stage 8: sum of squares.
  logic        s7_vld_r, s8_vld_r;
  side2_t      s7_r, s8_r;
  logic [63:0] s7_qx_r, s7_qy_r, s7_qz_r, s8_sum_r;

  always_ff @(posedge clk) begin
    s7_r     <= s6_r;
    s7_qx_r  <= 64'(s6_r.ux) * 64'(s6_r.ux);
    s7_qy_r  <= 64'(s6_r.uy) * 64'(s6_r.uy);
    s7_qz_r  <= 64'(s6_r.uz) * 64'(s6_r.uz);
    s8_r     <= s7_r;
    s8_sum_r <= s7_qx_r + s7_qy_r + s7_qz_r;
  end

  // Square root with matching sideband delay.
  logic [SQ_W-1:0] nrm;
  side2_t          d2_r  [SQ_W];
  logic            d2v_r [SQ_W];

  tlrg_sqrt u_sqrt (.clk(clk), .rad(s8_sum_r), .root(nrm));

  always_ff @(posedge clk) begin
    d2_r[0] <= s8_r;
    for (int s = 1; s < SQ_W; s++) begin
      d2_r[s] <= d2_r[s-1];
    end
  end

  // Stage 9: normalizing dividends.
  side2_t      e2;
  logic        s9_vld_r;
  logic [63:0] s9_nx_r, s9_ny_r, s9_nz_r;
  logic [31:0] s9_n_r;
  side3_t      s9_side_r;

  assign e2 = d2_r[SQ_W-1];

  always_ff @(posedge clk) begin
    s9_nx_r        <= (64'(e2.ux) << 30) + 64'(nrm >> 1);
    s9_ny_r        <= (64'(e2.uy) << 30) + 64'(nrm >> 1);
    s9_nz_r        <= (64'(e2.uz) << 30) + 64'(nrm >> 1);
    s9_n_r         <= nrm;
    s9_side_r.last <= e2.last;
    s9_side_r.negx <= e2.negx;
    s9_side_r.negy <= e2.negy;
    s9_side_r.ax   <= e2.ax;
    s9_side_r.ay   <= e2.ay;
  end

  logic [DIV_QW-1:0] qnx, qny, qnz;
  side3_t            d3_r  [DIV_QW];
  logic              d3v_r [DIV_QW];

  tlrg_div u_div_nx (.clk(clk), .num(s9_nx_r), .den(s9_n_r), .quo(qnx));
  tlrg_div u_div_ny (.clk(clk), .num(s9_ny_r), .den(s9_n_r), .quo(qny));
  tlrg_div u_div_nz (.clk(clk), .num(s9_nz_r), .den(s9_n_r), .quo(qnz));

  always_ff @(posedge clk) begin
    d3_r[0] <= s9_side_r;
    for (int s = 1; s < DIV_QW; s++) begin
      d3_r[s] <= d3_r[s-1];
    end
  end

  // Stage 10: cap, restore signs, output register.
  side3_t     e3;
  logic [30:0] cqx, cqy, cqz;
  logic        out_vld_r;
  out_item_t   out_r;

  always_comb begin
    e3  = d3_r[DIV_QW-1];
    cqx = (qnx > DIV_QW'(ONE_Q30)) ? 31'(ONE_Q30) : qnx[30:0];
    cqy = (qny > DIV_QW'(ONE_Q30)) ? 31'(ONE_Q30) : qny[30:0];
    cqz = (qnz > DIV_QW'(ONE_Q30)) ? 31'(ONE_Q30) : qnz[30:0];
  end

  always_ff @(posedge clk) begin
    out_r.origin_x <= e3.ax;
    out_r.origin_y <= e3.ay;
    out_r.dir_x    <= e3.negx ? -32'(cqx) : 32'(cqx);
    out_r.dir_y    <= e3.negy ? -32'(cqy) : 32'(cqy);
    out_r.dir_z    <= cqz;
    out_r.last_ray <= e3.last;
  end

  // Valid bits travel with the data through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int s = 0; s < DIV_QW; s++) begin
        d1v_r[s] <= 1'b0;
        d3v_r[s] <= 1'b0;
      end
      for (int s = 0; s < SQ_W; s++) begin
        d2v_r[s] <= 1'b0;
      end
    end else begin
      s1_vld_r <= smp.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      d1v_r[0] <= s3_vld_r;
      for (int s = 1; s < DIV_QW; s++) begin
        d1v_r[s] <= d1v_r[s-1];
        d3v_r[s] <= d3v_r[s-1];
      end
      s4_vld_r <= d1v_r[DIV_QW-1];
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
      d2v_r[0] <= s8_vld_r;
      for (int s = 1; s < SQ_W; s++) begin
        d2v_r[s] <= d2v_r[s-1];
      end
      s9_vld_r  <= d2v_r[SQ_W-1];
      d3v_r[0]  <= s9_vld_r;
      out_vld_r <= d3v_r[DIV_QW-1];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A pixel sweep has many slots, so a start transfer always makes the block busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after start transfer");

  // The z component can never round to zero: the slopes are bounded by 2^31.
  a_dir_z_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.dir_z != 31'd0 && out_data.dir_z <= 31'(ONE_Q30)))
    else $error("dir_z out of range");

  a_dir_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.dir_x <= 32'sh4000_0000 && out_data.dir_x >= -32'sh4000_0000))
    else $error("dir_x out of range");

  // A final ray is always preceded in the pipeline by a valid slope stage.
  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_vld_r && s4_last_r) |=> s5_vld_r)
    else $error("valid lost between slope and normalize stages");

endmodule

// File: verif/thin_lens_ray_generator_top_tb.sv
`timescale 1ns / 1ps
module thin_lens_ray_generator_top_tb import tlrg_pkg::*;;

  localparam longint ONE_30 = 64'sd1073741824;

  typedef struct {
    in_item_t           pix;
    bit                 chk;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
  } pix_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Camera settings as the predictor sees them.
  longint lens_diam;
  longint lens_disk;
  longint img_z;
  longint inv_focal;
  longint org_x;
  longint org_y;
  longint pitch_x;
  longint pitch_y;

  out_item_t ray_q[$];
  int        fail_cnt;
  longint    first_ox;
  longint    first_oy;

  pix_row_t pix_tbl[12] = '{
    '{'{12'd0,    12'd0},    1'b1, -32'sd24576, -32'sd24576},
    '{'{12'd4095, 12'd4095}, 1'b1, -32'sd24576, -32'sd24576},
    '{'{12'd0,    12'd4095}, 1'b1, -32'sd24576, -32'sd24576},
    '{'{12'd4095, 12'd0},    1'b1, -32'sd24576, -32'sd24576},
    '{'{12'd2048, 12'd2047}, 1'b0, 32'sd0, 32'sd0},
    '{'{12'd2730, 12'd1365}, 1'b0, 32'sd0, 32'sd0},
    '{'{12'd1365, 12'd2730}, 1'b0, 32'sd0, 32'sd0},
    '{'{12'd1,    12'd1},    1'b0, 32'sd0, 32'sd0},
    '{'{12'd3072, 12'd1024}, 1'b0, 32'sd0, 32'sd0},
    '{'{12'd4094, 12'd2},    1'b0, 32'sd0, 32'sd0},
    '{'{12'd64,   12'd4000}, 1'b0, 32'sd0, 32'sd0},
    '{'{12'd2047, 12'd2048}, 1'b0, 32'sd0, 32'sd0}
  };

  thin_lens_ray_generator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Division rounded to nearest, ties away from zero; d is positive.
  function automatic longint round_div(input longint n, input longint d);
    longint unsigned u;
    longint unsigned q;
    u = (n < 0) ? longint'(-n) : longint'(n);
    q = (u + longint'(d / 2)) / longint'(d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Queues every ray one pixel produces under the current camera settings.
  task automatic queue_pixel_rays(input in_item_t pix);
    longint          zm, ci, cj, ax, ay, gx, gy, sx, sy;
    longint unsigned ux, uy, uz, m, n, qx, qy, qz;
    out_item_t       r;
    out_item_t       batch[$];
    zm = (img_z < 0) ? -img_z : img_z;
    if (zm == 0) zm = 1;
    for (int i = 0; i < AP_N; i++) begin
      for (int j = 0; j < AP_N; j++) begin
        ci = 2 * i + 1 - AP_N;
        cj = 2 * j + 1 - AP_N;
        if (lens_disk != 0 && ci * ci + cj * cj >= AP_N * AP_N) continue;
        ax = round_div(lens_diam * ci, 2 * AP_N);
        ay = round_div(lens_diam * cj, 2 * AP_N);
        for (int k = 0; k < PX_N; k++) begin
          for (int l = 0; l < PX_N; l++) begin
            gx = clamp_s32(org_x + round_div((2 * PX_N * longint'(pix.pixel_x) + 2 * k + 1)
                                             * pitch_x, 2 * PX_N));
            gy = clamp_s32(org_y + round_div((2 * PX_N * longint'(pix.pixel_y) + 2 * l + 1)
                                             * pitch_y, 2 * PX_N));
            sx = clamp_s32(round_div((ax - gx) * 65536, zm) - round_div(inv_focal * ax, 65536));
            sy = clamp_s32(round_div((ay - gy) * 65536, zm) - round_div(inv_focal * ay, 65536));
            ux = (sx < 0) ? -sx : sx;
            uy = (sy < 0) ? -sy : sy;
            uz = 65536;
            m = (ux > uy) ? ux : uy;
            if (uz > m) m = uz;
            while (m < (64'd1 << 30)) begin
              ux = ux << 1;
              uy = uy << 1;
              uz = uz << 1;
              m = m << 1;
            end
            n = floor_sqrt(ux * ux + uy * uy + uz * uz);
            qx = ((ux << 30) + n / 2) / n;
            qy = ((uy << 30) + n / 2) / n;
            qz = ((uz << 30) + n / 2) / n;
            if (qx > ONE_30) qx = ONE_30;
            if (qy > ONE_30) qy = ONE_30;
            if (qz > ONE_30) qz = ONE_30;
            r.origin_x = ax[31:0];
            r.origin_y = ay[31:0];
            r.dir_x    = (sx < 0) ? -qx[31:0] : qx[31:0];
            r.dir_y    = (sy < 0) ? -qy[31:0] : qy[31:0];
            r.dir_z    = qz[30:0];
            r.last_ray = 1'b0;
            batch.push_back(r);
          end
        end
      end
    end
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.last_ray = 1'b1;
      batch.push_back(r);
      first_ox = longint'(batch[0].origin_x);
      first_oy = longint'(batch[0].origin_y);
    end
    foreach (batch[b]) ray_q.push_back(batch[b]);
  endtask

  // Result checker: every strobed ray is matched against the oldest expected one.
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid) begin
      if (ray_q.size() == 0) begin
        report_mismatch("unexpected ray, origin_x", longint'(out_data.origin_x), 0);
      end else begin
        w = ray_q.pop_front();
        if (out_data.origin_x !== w.origin_x)
          report_mismatch("origin_x", longint'(out_data.origin_x), longint'(w.origin_x));
        if (out_data.origin_y !== w.origin_y)
          report_mismatch("origin_y", longint'(out_data.origin_y), longint'(w.origin_y));
        if (out_data.dir_x !== w.dir_x)
          report_mismatch("dir_x", longint'(out_data.dir_x), longint'(w.dir_x));
        if (out_data.dir_y !== w.dir_y)
          report_mismatch("dir_y", longint'(out_data.dir_y), longint'(w.dir_y));
        if (out_data.dir_z !== w.dir_z)
          report_mismatch("dir_z", longint'(out_data.dir_z), longint'(w.dir_z));
        if (out_data.last_ray !== w.last_ray)
          report_mismatch("last_ray", longint'(out_data.last_ray), longint'(w.last_ray));
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic write_setting(input reg_idx_t idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DIAM:  lens_diam = longint'(v[30:0]);
      REG_DISK:  lens_disk = longint'(v[0]);
      REG_ZDIST: img_z     = longint'(signed'(v));
      REG_IFL:   inv_focal = longint'(signed'(v));
      REG_ORGX:  org_x     = longint'(signed'(v));
      REG_ORGY:  org_y     = longint'(signed'(v));
      REG_PITX:  pitch_x   = longint'(signed'(v));
      REG_PITY:  pitch_y   = longint'(signed'(v));
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (ray_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_camera(input logic [31:0] d, input logic [31:0] dk, input logic [31:0] z,
                              input logic [31:0] f, input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] ptx, input logic [31:0] pty);
    wait_drained();
    write_setting(REG_DIAM, d);
    write_setting(REG_DISK, dk);
    write_setting(REG_ZDIST, z);
    write_setting(REG_IFL, f);
    write_setting(REG_ORGX, ox);
    write_setting(REG_ORGY, oy);
    write_setting(REG_PITX, ptx);
    write_setting(REG_PITY, pty);
  endtask

  // Mostly plausible camera values, with a full-range value now and then.
  function automatic logic [31:0] rand_setting(input int lo, input int hi);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, hi - lo)) + lo);
  endfunction

  task automatic random_camera();
    logic [31:0] d;
    d = rand_setting(1, 200000) & 32'h7fff_ffff;
    if (d == 0) d = 1;
    write_camera(d, $urandom_range(0, 1), rand_setting(-300000, 300000),
                 rand_setting(-100000, 100000), rand_setting(-200000, 200000),
                 rand_setting(-200000, 200000), rand_setting(-2000, 2000),
                 rand_setting(-2000, 2000));
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input in_item_t pix);
    start   <= 1'b1;
    in_data <= pix;
    do @(posedge clk); while (busy);
    queue_pixel_rays(pix);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int g;
    if ($urandom_range(0, 2) == 0) g = 0;
    else if ($urandom_range(0, 9) == 0) g = $urandom_range(60, 300);
    else g = $urandom_range(1, 4);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic logic [11:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t pix;
    int       burst_pause;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    fail_cnt = 0;
    lens_diam = 65536;
    lens_disk = 0;
    img_z     = -65536;
    inv_focal = 0;
    org_x     = -65536;
    org_y     = -65536;
    pitch_x   = 32;
    pitch_y   = 32;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: the extreme corners of the camera, then other pixels.
    foreach (pix_tbl[r]) begin
      send_pixel(pix_tbl[r].pix);
      if (pix_tbl[r].chk) begin
        if (first_ox != longint'(pix_tbl[r].ox))
          report_mismatch("table origin_x", first_ox, longint'(pix_tbl[r].ox));
        if (first_oy != longint'(pix_tbl[r].oy))
          report_mismatch("table origin_y", first_oy, longint'(pix_tbl[r].oy));
      end
      sender_gap();
    end
    start <= 1'b0;
    // Disk aperture, widest lens, zero image distance, most negative focal term.
    write_camera(32'h7fff_ffff, 32'd1, 32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000);
    for (int r = 0; r < 6; r++) begin
      send_pixel(pix_tbl[r].pix);
      sender_gap();
    end
    start <= 1'b0;
    write_camera(32'd1, 32'd0, 32'd1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff);
    for (int r = 0; r < 6; r++) begin
      send_pixel(pix_tbl[r].pix);
      sender_gap();
    end
    start <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      random_camera();
      burst_pause = $urandom_range(20, 50);
      for (int n = 0; n < 68; n++) begin
        pix.pixel_x = rand_coord();
        pix.pixel_y = rand_coord();
        send_pixel(pix);
        if (n == burst_pause) begin
          start <= 1'b0;
          while (ray_q.size() != 0) @(negedge clk);
        end else if (ph == 2 && n < 30) begin
          // Back-to-back stretch.
        end else begin
          sender_gap();
        end
      end
      start <= 1'b0;
    end

    wait_drained();
    if (fail_cnt == 0 && ray_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tlrg_pkg.sv
rtl/tlrg_div.sv
rtl/tlrg_sqrt.sv
rtl/tlrg_seq.sv
rtl/thin_lens_ray_generator_top.sv
verif/thin_lens_ray_generator_top_tb.sv
